>>> hw/rtl/vmc_pkg.sv
`default_nettype none
package vmc_pkg;

  // register map
  localparam logic [1:0] CfgPotMode  = 2'd0;
  localparam logic [1:0] CfgCalibWin = 2'd1;
  localparam logic [1:0] CfgMargin   = 2'd2;
  localparam logic [1:0] CfgQuietest = 2'd3;

  // reset values
  localparam logic [15:0] CalibReset  = 16'd5000;
  localparam logic [7:0]  MarginReset = 8'd1;
  localparam logic [6:0]  QuietReset  = 7'd50;
  localparam logic [7:0]  LimitReset  = 8'd128;
  localparam logic [6:0]  LevelMax    = 7'd127;
  localparam logic [6:0]  LevelStep   = 7'd2;

  // quotient never exceeds the quietest level, so 7 bits are enough
  localparam int unsigned DivSteps = 7;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic latch;     // capture the poll
    logic eval;      // commit flags, limits and button levels
    logic mul;       // form numerator, load divider
    logic div_step;  // one restoring division step
    logic div_wr;    // write quotient to active level
    logic load_out;  // load the result register
  } vmc_cmd_t;

  typedef struct packed {
    logic need_div;  // pot mode, unmuted, positive span
  } vmc_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/vmc_ctrl.sv
`default_nettype none
module vmc_ctrl import vmc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire vmc_sts_t sts_i,
  output vmc_cmd_t      cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SEval = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SWb   = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = SEval;
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? SMul : SDone;
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = SWb;
        end
      end
      SWb: begin
        cmd_o.div_wr = 1'b1;
        state_d      = SDone;
      end
      SDone: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/vmc_dpath.sv
`default_nettype none
module vmc_dpath import vmc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [31:0] elapsed_ms_i,
  input  wire logic [7:0]  pot_sample_i,
  input  wire logic        headset_sense_i,
  input  wire logic        down_button_i,
  input  wire logic        up_button_i,
  input  wire vmc_cmd_t    cmd_i,
  output vmc_sts_t         sts_o,
  output logic [31:0]      result_o
);

  // configuration
  logic        pot_mode_q;
  logic [15:0] calib_q;
  logic [7:0]  margin_q;
  logic [6:0]  quiet_q;

  // architectural state
  logic       mute_q, mute_d;
  logic       headset_q, headset_d;
  logic [6:0] phones_q, phones_d;
  logic [6:0] spkr_q, spkr_d;
  logic [7:0] low_q, low_d;
  logic [7:0] high_q, high_d;
  logic       chord_q, chord_d;

  // captured poll
  logic [31:0] elapsed_q;
  logic [7:0]  sample_q;
  logic        sense_q, down_q, up_q;

  // divider
  logic [7:0]  diff_q;
  logic [7:0]  span_q;
  logic [7:0]  rem_q;
  logic [6:0]  shq_q;
  logic [14:0] num;
  logic [8:0]  trial;
  logic        qbit;

  logic [31:0] result_q;

  // pot evaluation
  logic               calib;
  logic [7:0]         low_n, high_n, smp;
  logic signed [10:0] thr, span;
  logic               pot_mute, span_pos;

  // button evaluation
  logic       head_n;
  logic [6:0] lvl, lvl_new;
  logic [7:0] lvl_inc;
  logic       lvl_wr;

  assign head_n = mute_q ? headset_q : sense_q;

  always_comb begin
    calib  = elapsed_q < {16'd0, calib_q};
    low_n  = low_q;
    high_n = high_q;
    smp    = sample_q;
    if (calib) begin
      if (sample_q < low_q)  low_n  = sample_q;
      if (sample_q > high_q) high_n = sample_q;
    end else begin
      if (sample_q > high_q) smp = high_q;
      else if (sample_q < low_q) smp = low_q;
    end
    thr      = $signed({3'b000, high_n}) - $signed({3'b000, margin_q});
    span     = thr - $signed({3'b000, low_n});
    pot_mute = $signed({3'b000, smp}) > thr;
    span_pos = span > 11'sd0;
  end

  assign sts_o.need_div = pot_mode_q && !pot_mute && span_pos;

  always_comb begin
    lvl     = head_n ? phones_q : spkr_q;
    lvl_inc = {1'b0, lvl} + {1'b0, LevelStep};
    lvl_new = lvl;
    lvl_wr  = 1'b0;
    if (down_q) begin
      if (lvl < quiet_q) begin
        lvl_wr  = 1'b1;
        lvl_new = (lvl_inc > {1'b0, LevelMax}) ? LevelMax : lvl_inc[6:0];
      end
    end else if (up_q) begin
      if (lvl != 7'd0) begin
        lvl_wr  = 1'b1;
        lvl_new = (lvl >= LevelStep) ? lvl - LevelStep : 7'd0;
      end
    end
  end

  // restoring step: remainder stays below span
  assign num   = diff_q * quiet_q;
  assign trial = {rem_q, shq_q[6]};
  assign qbit  = trial >= {1'b0, span_q};

  always_comb begin
    mute_d    = mute_q;
    headset_d = headset_q;
    phones_d  = phones_q;
    spkr_d    = spkr_q;
    low_d     = low_q;
    high_d    = high_q;
    chord_d   = chord_q;
    if (cmd_i.eval) begin
      headset_d = head_n;
      if (pot_mode_q) begin
        low_d  = low_n;
        high_d = high_n;
        mute_d = pot_mute;
        if (!pot_mute && !span_pos) begin
          if (head_n) phones_d = 7'd0;
          else        spkr_d   = 7'd0;
        end
      end else if (down_q && up_q) begin
        if (!chord_q) begin
          mute_d  = !mute_q;
          chord_d = 1'b1;
        end
      end else begin
        chord_d = 1'b0;
        if (!mute_q && lvl_wr) begin
          if (head_n) phones_d = lvl_new;
          else        spkr_d   = lvl_new;
        end
      end
    end
    if (cmd_i.div_wr) begin
      if (headset_q) phones_d = shq_q;
      else           spkr_d   = shq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_mode_q <= 1'b0;
      calib_q    <= CalibReset;
      margin_q   <= MarginReset;
      quiet_q    <= QuietReset;
      mute_q     <= 1'b0;
      headset_q  <= 1'b0;
      phones_q   <= '0;
      spkr_q     <= '0;
      low_q      <= LimitReset;
      high_q     <= LimitReset;
      chord_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPotMode:  pot_mode_q <= cfg_data_i[0];
          CfgCalibWin: calib_q    <= cfg_data_i;
          CfgMargin:   margin_q   <= cfg_data_i[7:0];
          CfgQuietest: quiet_q    <= cfg_data_i[6:0];
          default:     ;
        endcase
      end
      mute_q    <= mute_d;
      headset_q <= headset_d;
      phones_q  <= phones_d;
      spkr_q    <= spkr_d;
      low_q     <= low_d;
      high_q    <= high_d;
      chord_q   <= chord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      elapsed_q <= elapsed_ms_i;
      sample_q  <= pot_sample_i;
      sense_q   <= headset_sense_i;
      down_q    <= down_button_i;
      up_q      <= up_button_i;
    end
    if (cmd_i.eval) begin
      diff_q <= smp - low_n;
      span_q <= span[7:0];
    end
    if (cmd_i.mul) begin
      rem_q <= num[14:7];
      shq_q <= num[6:0];
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? 8'(trial - {1'b0, span_q}) : trial[7:0];
      shq_q <= {shq_q[5:0], qbit};
    end
    if (cmd_i.load_out) begin
      result_q <= {high_q, low_q, spkr_q, phones_q, headset_q, mute_q};
    end
  end

  assign result_o = result_q;

endmodule
`default_nettype wire

>>> hw/rtl/volume_mute_controller.sv
`default_nettype none
// Volume and mute controller for a headset/speaker output pair. Each request on the
// slave stream is one poll (elapsed time, wheel sample, headset sense, buttons) and
// yields exactly one result request on the master stream carrying the mute flag,
// routing, both attenuation codes and the learned wheel limits. Headset sense is
// only taken while unmuted. With pot_mode set the wheel limits widen inside the
// calibration window and the sample is clamped to them afterwards; samples above
// (high limit - mute margin) mute, others map linearly onto 0..quietest_level for
// the active output. With pot_mode clear, both buttons together toggle mute once
// per press and a single button steps the active level by 2.
// Timing: one poll at a time. A poll passes through evaluate and load when no
// division is needed, and through evaluate, multiply, 7 restoring divider steps at
// one quotient bit per cycle, write-back and load when the wheel mapping runs. A
// new poll is taken only once the previous one has loaded its result. A finished
// result waits in the output register; the input is ready again as soon as that
// register is loaded, and a following poll stalls only once its own result finds
// the register still full. Configuration writes are always accepted (cfg_ready_o
// is tied high) and must only be issued while idle.
module volume_mute_controller import vmc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // poll in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] elapsed_ms, [39:32] pot_sample, [40] headset_sense,
  // [41] down_button, [42] up_button, [47:43] zero
  input  wire logic [47:0] s_axis_tdata_i,
  // result out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] muted_now, [1] headset_active, [8:2] headphone_level,
  // [15:9] speaker_level, [23:16] pot_low_limit, [31:24] pot_high_limit
  output logic [31:0]      m_axis_tdata_o,
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  vmc_cmd_t cmd;
  vmc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vmc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ms_i    (s_axis_tdata_i[31:0]),
    .pot_sample_i    (s_axis_tdata_i[39:32]),
    .headset_sense_i (s_axis_tdata_i[40]),
    .down_button_i   (s_axis_tdata_i[41]),
    .up_button_i     (s_axis_tdata_i[42]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_o        (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/vmc_checker.sv
`default_nettype none
module vmc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);

  // limits only ever widen from a common start
  a_limits_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23:16] <= m_axis_tdata_o[31:24]))
    else $error("low limit above high limit");

  // one poll in flight: no accept on the cycle after an accept
  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("poll accepted while previous one in flight");

  // a poll passes through evaluation before its result shows
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind volume_mute_controller vmc_checker u_vmc_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Volume and mute controller bench. Polls go in on the slave stream in random
// bursts, status words come back on the master stream under a receiver that
// stalls in patterns of its own. Each status word is checked, field by field,
// against a local predictor of the controller kept alongside the stimulus.
module tb_top;
  import vmc_pkg::*;

  // idle cycles (no transfer on any channel) before the run is given up
  localparam int unsigned IdleLimit   = 2000;
  // cycles waited after the last status word before the summary
  localparam int unsigned DrainCycles = 24;
  // receiver hold-off used to fill the block and stall its input
  localparam int unsigned LongHold    = 300;
  localparam int unsigned PhaseItems  = 105;

  // one poll, last field in the lowest bits
  typedef struct packed {
    logic        up;
    logic        down;
    logic        sense;
    logic [7:0]  sample;
    logic [31:0] elapsed;
  } poll_t;

  // one status word, last field in the lowest bits
  typedef struct packed {
    logic [7:0] high_lim;
    logic [7:0] low_lim;
    logic [6:0] spkr;
    logic [6:0] phones;
    logic       headset;
    logic       mute;
  } status_t;

  typedef enum logic [1:0] {RxOpen, RxSparse, RxPeriodic, RxCoin} rx_mode_e;

  // ---------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = CfgPotMode;
  logic [15:0] cfg_data_i      = '0;

  volume_mute_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller predictor: registers and state mirrored at reset values
  // ---------------------------------------------------------------------------
  logic        cf_pot    = 1'b0;
  logic [15:0] cf_calib  = CalibReset;
  logic [7:0]  cf_margin = MarginReset;
  logic [6:0]  cf_quiet  = QuietReset;

  logic        mute_q    = 1'b0;
  logic        headset_q = 1'b0;
  logic        chord_q   = 1'b0;
  logic [6:0]  phones_q  = '0;
  logic [6:0]  spkr_q    = '0;
  logic [7:0]  low_q     = LimitReset;
  logic [7:0]  high_q    = LimitReset;

  status_t status_due[$];   // predicted status words, oldest first

  // bookkeeping
  int unsigned polls_sent   = 0;
  int unsigned wheel_polls  = 0;
  int unsigned results_seen = 0;
  int unsigned muted_seen   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned errors       = 0;

  function automatic void set_active_level(input int lvl);
    if (headset_q) phones_q = lvl[6:0];
    else spkr_q = lvl[6:0];
  endfunction

  // advance the controller by one poll and return the status it reports
  function automatic status_t poll_controller(input poll_t p);
    int      smp;
    int      thr;
    int      span;
    int      num;
    int      lvl;
    status_t st;
    if (!mute_q) headset_q = p.sense;
    if (cf_pot) begin
      smp = p.sample;
      if (p.elapsed < {16'd0, cf_calib}) begin
        // calibration window: limits only widen
        if (p.sample < low_q) low_q = p.sample;
        if (p.sample > high_q) high_q = p.sample;
      end else begin
        if (smp > int'(high_q)) smp = high_q;
        if (smp < int'(low_q)) smp = low_q;
      end
      // threshold may go negative when the margin exceeds the high limit
      thr = int'(high_q) - int'(cf_margin);
      if (smp > thr) begin
        mute_q = 1'b1;
      end else begin
        mute_q = 1'b0;
        span = thr - int'(low_q);
        if (span <= 0) begin
          set_active_level(0);
        end else begin
          num = (smp - int'(low_q)) * int'(cf_quiet);
          if (num < 0) num = 0;
          set_active_level(num / span);
        end
      end
    end else if (p.down && p.up) begin
      // chord toggles once per press
      if (!chord_q) begin
        mute_q  = !mute_q;
        chord_q = 1'b1;
      end
    end else begin
      chord_q = 1'b0;
      if (!mute_q) begin
        lvl = headset_q ? phones_q : spkr_q;
        if (p.down) begin
          if (lvl < int'(cf_quiet)) begin
            lvl = lvl + int'(LevelStep);
            set_active_level((lvl > int'(LevelMax)) ? int'(LevelMax) : lvl);
          end
        end else if (p.up && lvl > 0) begin
          set_active_level((lvl >= int'(LevelStep)) ? lvl - int'(LevelStep) : 0);
        end
      end
    end
    st.mute     = mute_q;
    st.headset  = headset_q;
    st.phones   = phones_q;
    st.spkr     = spkr_q;
    st.low_lim  = low_q;
    st.high_lim = high_q;
    return st;
  endfunction

  function automatic poll_t make_poll(input logic [31:0] elapsed, input logic [7:0] sample,
                                      input logic sense, input logic down, input logic up);
    poll_t p;
    p.elapsed = elapsed;
    p.sample  = sample;
    p.sense   = sense;
    p.down    = down;
    p.up      = up;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes: all four in a row, valid lowered only after the last
  // ---------------------------------------------------------------------------
  task automatic configure(input logic pot, input logic [15:0] calib,
                           input logic [7:0] margin, input logic [6:0] quiet);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{CfgPotMode, CfgCalibWin, CfgMargin, CfgQuietest};
    vals = '{{15'd0, pot}, calib, {8'd0, margin}, {9'd0, quiet}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
    cf_pot    = pot;
    cf_calib  = calib;
    cf_margin = margin;
    cf_quiet  = quiet;
  endtask

  // ---------------------------------------------------------------------------
  // Poll sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;

  task automatic send_poll(input poll_t p);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, p};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    status_due.push_back(poll_controller(p));
    polls_sent++;
    if (cf_pot) wheel_polls++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        burst_left = $urandom_range(0, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering polls and wait for every predicted status word
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pattern redrawn at rx_cycle[5:0] == 0; long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_cycle    = 0;
  rx_mode_e    rx_mode     = RxOpen;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done      <= holds_done + 1;
      hold_left       <= LongHold;
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RxOpen:     m_axis_tready_i <= 1'b1;
        RxSparse:   m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        RxPeriodic: m_axis_tready_i <= ((rx_cycle % 7) >= 3);
        default:    m_axis_tready_i <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Status checker
  // ---------------------------------------------------------------------------
  status_t got;
  status_t want;

  function automatic void check_field(input string what, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = status_t'(m_axis_tdata_o);
      if (status_due.size() == 0) begin
        $display("%0t ns: unexpected status, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = status_due.pop_front();
        results_seen++;
        if (got.mute) muted_seen++;
        check_field("muted_now", want.mute, got.mute);
        check_field("headset_active", want.headset, got.headset);
        check_field("headphone_level", want.phones, got.phones);
        check_field("speaker_level", want.spkr, got.spkr);
        check_field("pot_low_limit", want.low_lim, got.low_lim);
        check_field("pot_high_limit", want.high_lim, got.high_lim);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles with no transfer on any channel
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t ns: no progress for %0d cycles", $time, IdleLimit);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [31:0] now_ms     = '0;
  logic        sense_line = 1'b0;
  int          wheel_pos  = 128;

  // a button gesture: chord held, single button run, nothing, or noise
  task automatic send_button_gesture();
    int unsigned kind;
    int unsigned len;
    poll_t       p;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 6);
    if ($urandom_range(0, 15) == 0) sense_line = !sense_line;
    for (int i = 0; i < len; i++) begin
      now_ms = now_ms + $urandom_range(1, 40);
      p = make_poll(now_ms, 8'($urandom), sense_line, 1'b0, 1'b0);
      case (kind)
        0, 1:    begin
          p.down = 1'b1;
          p.up   = 1'b1;
        end
        2, 3, 4: p.down = 1'b1;
        5, 6, 7: p.up = 1'b1;
        8:       ;
        default: begin
          p.down    = 1'($urandom_range(0, 1));
          p.up      = 1'($urandom_range(0, 1));
          p.sense   = 1'($urandom_range(0, 1));
          p.elapsed = $urandom;
        end
      endcase
      send_poll(p);
    end
  endtask

  // wheel poll: slow drift with jumps to the ends, time around the window edge
  task automatic send_wheel_poll();
    logic [31:0] t;
    case ($urandom_range(0, 7))
      0:       wheel_pos = 0;
      1:       wheel_pos = 255;
      2:       wheel_pos = $urandom_range(0, 255);
      default: wheel_pos += int'($urandom_range(0, 40)) - 20;
    endcase
    if (wheel_pos < 0) wheel_pos = 0;
    if (wheel_pos > 255) wheel_pos = 255;
    case ($urandom_range(0, 5))
      0:       t = $urandom;
      1:       t = {16'd0, cf_calib};
      2:       t = {16'd0, cf_calib} - 32'd1;
      default: t = $urandom_range(0, 32'h1_FFFF);
    endcase
    if ($urandom_range(0, 31) == 0) sense_line = !sense_line;
    send_poll(make_poll(t, 8'(wheel_pos), sense_line,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // button mode at reset settings: steps, routing, chord press and hold
  task automatic test_reset_defaults();
    send_poll(make_poll(32'd0, 8'h00, 1'b0, 1'b1, 1'b0));
    send_poll(make_poll(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b1));
    send_poll(make_poll(32'd10, 8'h55, 1'b1, 1'b1, 1'b0));
    send_poll(make_poll(32'd20, 8'hAA, 1'b1, 1'b1, 1'b1));   // chord: mute
    send_poll(make_poll(32'd30, 8'h0F, 1'b0, 1'b1, 1'b1));   // held: no toggle
    send_poll(make_poll(32'd40, 8'hF0, 1'b0, 1'b1, 1'b0));   // release, step ignored
    send_poll(make_poll(32'd50, 8'h01, 1'b0, 1'b1, 1'b1));   // chord: unmute
    send_poll(make_poll(32'd60, 8'h80, 1'b1, 1'b0, 1'b0));
    drain();
  endtask

  // wheel mode: empty span, negative threshold, learning and clamping
  task automatic test_pot_calibration();
    configure(1'b1, 16'd0, 8'd0, 7'd126);
    send_poll(make_poll(32'd0, 8'h00, 1'b0, 1'b0, 1'b0));     // zero span
    send_poll(make_poll(32'd5, 8'hFF, 1'b0, 1'b0, 1'b0));
    drain();
    configure(1'b1, 16'd0, 8'hFF, 7'd126);
    send_poll(make_poll(32'd9, 8'h00, 1'b1, 1'b0, 1'b0));     // margin over high: mute
    send_poll(make_poll(32'd12, 8'h80, 1'b0, 1'b1, 1'b1));    // sense ignored
    drain();
    configure(1'b1, 16'hFFFF, 8'd0, 7'd126);
    send_poll(make_poll(32'd0, 8'h00, 1'b0, 1'b0, 1'b0));     // low limit learnt
    send_poll(make_poll(32'd1, 8'd200, 1'b0, 1'b0, 1'b0));    // high limit learnt
    send_poll(make_poll(32'd2, 8'd3, 1'b1, 1'b0, 1'b0));
    send_poll(make_poll(32'd65535, 8'hFF, 1'b1, 1'b0, 1'b0)); // clamped to high
    send_poll(make_poll(32'd65534, 8'hFF, 1'b0, 1'b0, 1'b0)); // widens to full
    send_poll(make_poll(32'hFFFF_FFFF, 8'd253, 1'b0, 1'b0, 1'b0)); // speaker odd
    send_poll(make_poll(32'hFFFF_FFFF, 8'd3, 1'b1, 1'b0, 1'b0));   // phones at 1
    drain();
  endtask

  // button steps at both ends of the scale, with levels left by the wheel
  task automatic test_button_limits();
    configure(1'b0, CalibReset, MarginReset, 7'd126);
    send_poll(make_poll(32'd100, 8'h00, 1'b0, 1'b1, 1'b0));   // saturates high
    send_poll(make_poll(32'd101, 8'h00, 1'b0, 1'b1, 1'b0));   // already above quietest
    send_poll(make_poll(32'd102, 8'h00, 1'b1, 1'b0, 1'b1));   // from 1 to 0
    send_poll(make_poll(32'd103, 8'h00, 1'b1, 1'b0, 1'b1));   // stays at 0
    drain();
  endtask

  // receiver holds off while polls keep coming, then the sender waits it out
  task automatic test_backpressure();
    gaps_on = 1'b0;
    holds_asked++;
    repeat (30) send_button_gesture();
    gaps_on = 1'b1;
    drain();
  endtask

  // random phases over register settings, extremes first
  task automatic test_random_phases();
    int unsigned target;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       configure(1'b0, 16'd0, 8'd0, 7'd0);
        1:       configure(1'b1, 16'hFFFF, 8'hFF, 7'd126);
        2:       configure(1'b1, 16'd0, 8'd0, 7'd0);
        3:       configure(1'b0, 16'hFFFF, 8'hFF, 7'd126);
        4:       configure(1'b1, 16'd0, 8'd0, 7'd126);
        default: configure(1'($urandom), 16'($urandom), 8'($urandom),
                           7'($urandom_range(0, 126)));
      endcase
      target = polls_sent + PhaseItems;
      while (polls_sent < target) begin
        if (cf_pot) send_wheel_poll();
        else send_button_gesture();
      end
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_pot_calibration();
    test_button_limits();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d polls (%0d in wheel mode) over %0d register writes.",
             polls_sent, wheel_polls, cfg_writes);
    $display("Checked %0d status words, %0d of them muted; %0d mismatches.",
             results_seen, muted_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
